// ----- hw/rtl/bfslc_pkg.sv -----
// Package: transaction types, mode encodings, register indexes and the LED colour table.
package bfslc_pkg;

   // Input transaction: one 1 ms tick with raw pin levels
   typedef struct packed {
      logic button_level;
      logic ir_level;
   } req_type;

   // Result transaction: lamp, IR carrier enable, RGB LEDs and status
   typedef struct packed {
      logic lamp_on;
      logic ir_burst;
      logic led1_red;
      logic led1_green;
      logic led1_blue;
      logic led2_red;
      logic led2_green;
      logic led2_blue;
      logic together;
      logic pressed;
   } rsp_type;

   // Flashlight modes
   typedef enum logic [3:0] {
      LAMP_IDLE       = 4'd0,
      LAMP_PRESS      = 4'd1,
      LAMP_SHORT      = 4'd2,
      LAMP_BLINK_OFF  = 4'd3,
      LAMP_BLINK_ON   = 4'd4,
      LAMP_LONG_HELD  = 4'd5,
      LAMP_LONG_ON    = 4'd6,
      LAMP_WARN_OFF   = 4'd7,
      LAMP_WARN_ON    = 4'd8
   } lamp_mode_type;

   // IR sync / presence modes
   typedef enum logic [2:0] {
      SYNC_LISTEN      = 3'd0,
      SYNC_TX          = 3'd1,
      SYNC_TX_GAP      = 3'd2,
      SYNC_TX_QUIET    = 3'd3,
      SYNC_REPLY_WAIT  = 3'd4,
      SYNC_REPLY_TX    = 3'd5,
      SYNC_REPLY_QUIET = 3'd6
   } sync_mode_type;

   // Configuration register indexes
   localparam logic [3:0] CSR_PRESS_WINDOW      = 4'd0;
   localparam logic [3:0] CSR_SHORT_ON_EXTRA    = 4'd1;
   localparam logic [3:0] CSR_BLINK_HALF_PERIOD = 4'd2;
   localparam logic [3:0] CSR_LONG_ON_TIME      = 4'd3;
   localparam logic [3:0] CSR_WARN_OFF_TIME     = 4'd4;
   localparam logic [3:0] CSR_WARN_ON_TIME      = 4'd5;
   localparam logic [3:0] CSR_SYNC_INTERVAL     = 4'd6;
   localparam logic [3:0] CSR_TOGETHER_HOLD     = 4'd7;

   // Configuration reset values
   localparam logic [14:0] PRESS_WINDOW_RST      = 15'd500;
   localparam logic [15:0] SHORT_ON_EXTRA_RST    = 16'd9500;
   localparam logic [15:0] BLINK_HALF_PERIOD_RST = 16'd500;
   localparam logic [15:0] LONG_ON_TIME_RST      = 16'd50000;
   localparam logic [15:0] WARN_OFF_TIME_RST     = 16'd100;
   localparam logic [15:0] WARN_ON_TIME_RST      = 16'd2000;
   localparam logic [15:0] SYNC_INTERVAL_RST     = 16'd30000;
   localparam logic [15:0] TOGETHER_HOLD_RST     = 16'd65535;

   // Sync sequence timing in ticks
   localparam logic [15:0] SYNC_TIMER_RST   = 16'd60000;
   localparam logic [15:0] SYNC_TX_TIME     = 16'd10;
   localparam logic [15:0] SYNC_GAP_TIME    = 16'd25;
   localparam logic [15:0] SYNC_QUIET_TIME  = 16'd100;
   localparam logic [15:0] SYNC_REPLY_DELAY = 16'd50;
   localparam logic [15:0] SYNC_REPLY_QUIET_TIME = 16'd75;
   localparam logic [15:0] TIMER_MAX        = 16'hffff;

   // LED bit positions: {B2, G2, R2, B1, G1, R1}
   localparam logic [5:0] LED_R1 = 6'h01;
   localparam logic [5:0] LED_G1 = 6'h02;
   localparam logic [5:0] LED_B1 = 6'h04;
   localparam logic [5:0] LED_R2 = 6'h08;
   localparam logic [5:0] LED_G2 = 6'h10;
   localparam logic [5:0] LED_B2 = 6'h20;

   // Together colour table: slot picks the row, phase picks one of two entries
   function automatic logic [5:0] colour_lookup(input logic [3:0] slot, input logic phase);
      logic [5:0] a;
      logic [5:0] b;
      begin
         a = '0;
         b = '0;
         case (slot)
            4'd0:  begin a = '0;     b = LED_R1; end
            4'd1:  begin a = LED_B2; b = LED_G2; end
            4'd2:  begin a = LED_G1; b = LED_R1; end
            4'd3:  begin a = '0;     b = LED_B2; end
            4'd4:  begin a = '0;     b = LED_G1; end
            4'd5:  begin a = LED_B2; b = LED_R2; end
            4'd6:  begin a = LED_B1; b = LED_G1; end
            4'd7:  begin a = '0;     b = LED_R2; end
            4'd8:  begin a = '0;     b = LED_B1; end
            4'd9:  begin a = LED_G2; b = LED_R2; end
            4'd10: begin a = LED_B1; b = LED_R1; end
            4'd11: begin a = '0;     b = LED_G2; end
            default: begin a = '0;   b = '0; end
         endcase
         colour_lookup = phase ? b : a;
      end
   endfunction

endpackage

// ----- hw/rtl/button_flashlight_sync_led_controller_top.sv -----
// A tick transaction's result is registered and offered in the cycle after acceptance.
// Throughput: one tick per cycle while rsp_ready holds; the result register lets the next tick enter while it drains.
// All per-tick work (timers, debounce filters, both mode machines, LED pick) is one register stage.
// Reset (synchronous, active high) restores the configuration defaults and the power-up state:
// lamp off, sync listening with 60000 ticks to first pulse, alone, button filter all released.
// Top level: flashlight and IR sync LED controller.
module button_flashlight_sync_led_controller_top #(
   parameter int PATTERN_LENGTH    = 6144,
   parameter int BUTTON_FILTER_LEN = 8,
   parameter int IR_FILTER_LEN     = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bfslc_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bfslc_pkg::rsp_type rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [3:0]         csr_index,
   input  logic [15:0]        csr_data
);
   import bfslc_pkg::*;

   localparam int PC_W = $clog2(PATTERN_LENGTH);

   // Configuration registers
   logic [14:0] press_window_ff;
   logic [15:0] short_on_extra_ff;
   logic [15:0] blink_half_period_ff;
   logic [15:0] long_on_time_ff;
   logic [15:0] warn_off_time_ff;
   logic [15:0] warn_on_time_ff;
   logic [15:0] sync_interval_ff;
   logic [15:0] together_hold_ff;

   // Tick state
   lamp_mode_type          lamp_mode_ff, lamp_mode_in;
   logic [15:0]            lamp_timer_ff, lamp_timer_in;
   logic                   lamp_lit_ff, lamp_lit_in;
   sync_mode_type          sync_mode_ff, sync_mode_in;
   logic [15:0]            sync_timer_ff, sync_timer_in;
   logic [15:0]            company_timer_ff, company_timer_in;
   logic [PC_W-1:0]        pattern_ff, pattern_in;
   logic [BUTTON_FILTER_LEN-1:0] button_hist_ff, button_hist_in;
   logic                   debounced_ff, debounced_in;
   logic [IR_FILTER_LEN-1:0] ir_hist_ff, ir_hist_in;
   logic [1:0]             ir_edge_ff, ir_edge_in;

   // Result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_in;

   // Working values
   logic        step_en;
   logic [PC_W:0] pattern_sum;
   logic [15:0] pattern_wide;
   logic [15:0] lamp_dec, sync_dec, company_dec;
   logic [16:0] short_sum;
   logic        pr, ir_edge_hit;
   logic [5:0]  leds;

   assign step_en   = req_valid && req_ready;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         press_window_ff      <= PRESS_WINDOW_RST;
         short_on_extra_ff    <= SHORT_ON_EXTRA_RST;
         blink_half_period_ff <= BLINK_HALF_PERIOD_RST;
         long_on_time_ff      <= LONG_ON_TIME_RST;
         warn_off_time_ff     <= WARN_OFF_TIME_RST;
         warn_on_time_ff      <= WARN_ON_TIME_RST;
         sync_interval_ff     <= SYNC_INTERVAL_RST;
         together_hold_ff     <= TOGETHER_HOLD_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PRESS_WINDOW:      press_window_ff      <= csr_data[14:0];
            CSR_SHORT_ON_EXTRA:    short_on_extra_ff    <= csr_data;
            CSR_BLINK_HALF_PERIOD: blink_half_period_ff <= csr_data;
            CSR_LONG_ON_TIME:      long_on_time_ff      <= csr_data;
            CSR_WARN_OFF_TIME:     warn_off_time_ff     <= csr_data;
            CSR_WARN_ON_TIME:      warn_on_time_ff      <= csr_data;
            CSR_SYNC_INTERVAL:     sync_interval_ff     <= csr_data;
            CSR_TOGETHER_HOLD:     together_hold_ff     <= csr_data;
            default: ;
         endcase
      end
   end

   // Pattern counter, timers and debounce filters
   always_comb begin
      pattern_sum = {1'b0, pattern_ff} + (PC_W+1)'(1);
      pattern_in  = (pattern_sum >= (PC_W+1)'(PATTERN_LENGTH)) ? '0 : pattern_sum[PC_W-1:0];
      pattern_wide = 16'(pattern_in);

      lamp_dec    = (lamp_timer_ff == '0) ? '0 : lamp_timer_ff - 16'd1;
      sync_dec    = (sync_timer_ff == '0) ? '0 : sync_timer_ff - 16'd1;
      company_dec = (company_timer_ff == '0) ? '0 : company_timer_ff - 16'd1;

      button_hist_in = {button_hist_ff[BUTTON_FILTER_LEN-2:0], req_data.button_level};
      debounced_in   = debounced_ff;
      if (button_hist_in == '1) debounced_in = 1'b0;
      if (button_hist_in == '0) debounced_in = 1'b1;

      ir_hist_in = {ir_hist_ff[IR_FILTER_LEN-2:0], req_data.ir_level};
      ir_edge_in = ir_edge_ff;
      if (ir_hist_in == '1) begin
         ir_edge_in = {ir_edge_ff[0], 1'b0};
      end else if (ir_hist_in == '0) begin
         ir_edge_in = {ir_edge_ff[0], 1'b1};
      end

      pr          = debounced_in;
      ir_edge_hit = (ir_edge_in == 2'b01);
   end

   // Flashlight machine next state
   always_comb begin
      lamp_mode_in  = lamp_mode_ff;
      lamp_timer_in = lamp_dec;
      lamp_lit_in   = lamp_lit_ff;
      short_sum     = {1'b0, lamp_dec} + {1'b0, short_on_extra_ff};
      case (lamp_mode_ff)
         LAMP_IDLE: begin
            if (pr) begin
               lamp_lit_in   = 1'b1;
               lamp_mode_in  = LAMP_PRESS;
               lamp_timer_in = 16'(press_window_ff);
            end
         end
         LAMP_PRESS: begin
            if (!pr) begin
               lamp_timer_in = short_sum[16] ? TIMER_MAX : short_sum[15:0];
               lamp_mode_in  = LAMP_SHORT;
            end else if (lamp_dec == '0) begin
               lamp_mode_in = LAMP_LONG_HELD;
            end
         end
         LAMP_SHORT: begin
            if (pr) begin
               lamp_mode_in  = LAMP_BLINK_OFF;
               lamp_lit_in   = 1'b0;
               lamp_timer_in = blink_half_period_ff;
            end else if (lamp_dec == '0) begin
               lamp_lit_in  = 1'b0;
               lamp_mode_in = LAMP_IDLE;
            end
         end
         LAMP_BLINK_OFF: begin
            if (!pr) begin
               lamp_mode_in = LAMP_IDLE;
            end else if (lamp_dec == '0) begin
               lamp_mode_in  = LAMP_BLINK_ON;
               lamp_lit_in   = 1'b1;
               lamp_timer_in = blink_half_period_ff;
            end
         end
         LAMP_BLINK_ON: begin
            if (!pr) begin
               lamp_mode_in = LAMP_IDLE;
               lamp_lit_in  = 1'b0;
            end else if (lamp_dec == '0) begin
               lamp_mode_in  = LAMP_BLINK_OFF;
               lamp_lit_in   = 1'b0;
               lamp_timer_in = blink_half_period_ff;
            end
         end
         LAMP_LONG_HELD: begin
            if (!pr) begin
               lamp_mode_in  = LAMP_LONG_ON;
               lamp_timer_in = long_on_time_ff;
            end
         end
         LAMP_LONG_ON: begin
            if (pr) begin
               lamp_mode_in  = LAMP_BLINK_OFF;
               lamp_lit_in   = 1'b0;
               lamp_timer_in = blink_half_period_ff;
            end else if (lamp_dec == '0) begin
               lamp_mode_in  = LAMP_WARN_OFF;
               lamp_lit_in   = 1'b0;
               lamp_timer_in = warn_off_time_ff;
            end
         end
         LAMP_WARN_OFF: begin
            if (lamp_dec == '0) begin
               lamp_mode_in  = LAMP_WARN_ON;
               lamp_lit_in   = 1'b1;
               lamp_timer_in = warn_on_time_ff;
            end
         end
         LAMP_WARN_ON: begin
            if (pr) begin
               lamp_mode_in = LAMP_LONG_HELD;
            end else if (lamp_dec == '0) begin
               lamp_mode_in = LAMP_IDLE;
               lamp_lit_in  = 1'b0;
            end
         end
         default: lamp_mode_in = LAMP_IDLE;
      endcase
   end

   // Sync / presence machine next state
   always_comb begin
      sync_mode_in     = sync_mode_ff;
      sync_timer_in    = sync_dec;
      company_timer_in = company_dec;
      case (sync_mode_ff)
         SYNC_LISTEN: begin
            if (sync_dec == '0) begin
               sync_mode_in  = SYNC_TX;
               sync_timer_in = SYNC_TX_TIME;
            end else if (ir_edge_hit) begin
               sync_mode_in     = SYNC_REPLY_WAIT;
               company_timer_in = together_hold_ff;
               sync_timer_in    = SYNC_REPLY_DELAY;
            end
         end
         SYNC_TX: begin
            if (sync_dec == '0) begin
               sync_mode_in  = SYNC_TX_GAP;
               sync_timer_in = SYNC_GAP_TIME;
            end
         end
         SYNC_TX_GAP: begin
            if (sync_dec == '0) begin
               sync_mode_in  = SYNC_TX_QUIET;
               sync_timer_in = SYNC_QUIET_TIME;
            end
         end
         SYNC_TX_QUIET: begin
            if (sync_dec == '0) begin
               sync_mode_in  = SYNC_LISTEN;
               sync_timer_in = sync_interval_ff;
            end else if (ir_edge_hit) begin
               company_timer_in = together_hold_ff;
            end
         end
         SYNC_REPLY_WAIT: begin
            if (sync_dec == '0) begin
               sync_mode_in  = SYNC_REPLY_TX;
               sync_timer_in = SYNC_TX_TIME;
            end
         end
         SYNC_REPLY_TX: begin
            if (sync_dec == '0) begin
               sync_mode_in  = SYNC_REPLY_QUIET;
               sync_timer_in = SYNC_REPLY_QUIET_TIME;
            end
         end
         SYNC_REPLY_QUIET: begin
            if (sync_dec == '0) begin
               sync_mode_in  = SYNC_LISTEN;
               sync_timer_in = sync_interval_ff;
            end
         end
         default: sync_mode_in = SYNC_LISTEN;
      endcase
   end

   // LED pattern and result assembly
   always_comb begin
      leds = '0;
      if (!lamp_lit_in) begin
         if (company_timer_in != '0) begin
            leds = colour_lookup(pattern_wide[12:9], pattern_wide[0]);
         end else if (pattern_wide[10:3] == 8'h80) begin
            case (pattern_wide[1:0])
               2'd0:    leds = LED_R1 | LED_G2;
               2'd1:    leds = LED_G1 | LED_B2;
               2'd2:    leds = LED_B1 | LED_R2;
               default: leds = '0;
            endcase
         end
      end
      rsp_in.lamp_on    = lamp_lit_in;
      rsp_in.ir_burst   = (sync_mode_in == SYNC_TX) || (sync_mode_in == SYNC_REPLY_TX);
      rsp_in.led1_red   = |(leds & LED_R1);
      rsp_in.led1_green = |(leds & LED_G1);
      rsp_in.led1_blue  = |(leds & LED_B1);
      rsp_in.led2_red   = |(leds & LED_R2);
      rsp_in.led2_green = |(leds & LED_G2);
      rsp_in.led2_blue  = |(leds & LED_B2);
      rsp_in.together   = (company_timer_in != '0);
      rsp_in.pressed    = debounced_in;
   end

   // Advance tick state on each accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         lamp_mode_ff     <= LAMP_IDLE;
         lamp_timer_ff    <= '0;
         lamp_lit_ff      <= 1'b0;
         sync_mode_ff     <= SYNC_LISTEN;
         sync_timer_ff    <= SYNC_TIMER_RST;
         company_timer_ff <= '0;
         pattern_ff       <= '0;
         button_hist_ff   <= '1;
         debounced_ff     <= 1'b0;
         ir_hist_ff       <= '0;
         ir_edge_ff       <= '0;
      end else if (step_en) begin
         lamp_mode_ff     <= lamp_mode_in;
         lamp_timer_ff    <= lamp_timer_in;
         lamp_lit_ff      <= lamp_lit_in;
         sync_mode_ff     <= sync_mode_in;
         sync_timer_ff    <= sync_timer_in;
         company_timer_ff <= company_timer_in;
         pattern_ff       <= pattern_in;
         button_hist_ff   <= button_hist_in;
         debounced_ff     <= debounced_in;
         ir_hist_ff       <= ir_hist_in;
         ir_edge_ff       <= ir_edge_in;
      end
   end

   // Hold the result until it is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step_en) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         rsp_data_ff <= rsp_in;
      end
   end

   // Lamp light and RGB LEDs never show together
   a_lamp_dark_leds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.lamp_on |->
         !(rsp_data_ff.led1_red || rsp_data_ff.led1_green || rsp_data_ff.led1_blue ||
           rsp_data_ff.led2_red || rsp_data_ff.led2_green || rsp_data_ff.led2_blue))
      else $error("RGB LED lit while lamp is on");

   // Carrier enable follows the stored sync mode
   a_burst_mode: assert property (@(posedge clock) disable iff (reset)
      step_en |=> rsp_valid_ff && (rsp_data_ff.ir_burst ==
         ((sync_mode_ff == SYNC_TX) || (sync_mode_ff == SYNC_REPLY_TX))))
      else $error("ir_burst disagrees with sync mode");

   // Together, pressed and lamp_on flags follow the stored state
   a_status_state: assert property (@(posedge clock) disable iff (reset)
      step_en |=> (rsp_data_ff.together == (company_timer_ff != '0)) &&
                  (rsp_data_ff.pressed == debounced_ff) &&
                  (rsp_data_ff.lamp_on == lamp_lit_ff))
      else $error("status outputs disagree with stored state");

   // An empty result register always takes a new transaction
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with empty result register");

endmodule
